>>> rtl/rational_arith_unit_assert.svh
// Assertion macros used by the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define RAU_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define RAU_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rau_pkg.sv
// Shared types, codes and helpers for the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

  // Operand and product widths
  localparam int FW = 32;
  localparam int PW = 64;
  localparam int LIMIT_W = 31;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd10000000;

  // Stream widths
  localparam int IN_W = 136;
  localparam int OUT_W = 72;

  // Opcodes
  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_MUL    = 4'd2;
  localparam logic [3:0] OP_DIV    = 4'd3;
  localparam logic [3:0] OP_MOD    = 4'd4;
  localparam logic [3:0] OP_LT     = 4'd5;
  localparam logic [3:0] OP_GT     = 4'd6;
  localparam logic [3:0] OP_LE     = 4'd7;
  localparam logic [3:0] OP_GE     = 4'd8;
  localparam logic [3:0] OP_EQ     = 4'd9;
  localparam logic [3:0] OP_REDUCE = 4'd10;
  localparam logic [3:0] OP_NAT    = 4'd11;

  // Error codes
  localparam logic [2:0] ERR_OK   = 3'd0;
  localparam logic [2:0] ERR_ZDEN = 3'd1;
  localparam logic [2:0] ERR_DIVZ = 3'd2;
  localparam logic [2:0] ERR_OVF  = 3'd3;
  localparam logic [2:0] ERR_OPC  = 3'd4;

  // Status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [FW-1:0] mag32(input logic signed [FW-1:0] x);
    return x[FW-1] ? FW'(-x) : FW'(x);
  endfunction

  function automatic logic [PW-1:0] mag64(input logic signed [PW-1:0] x);
    return x[PW-1] ? PW'(-x) : PW'(x);
  endfunction

endpackage

`default_nettype wire

>>> rtl/rational_arith_unit.sv
// Top level: sequencer around a shared multiplier, divider and gcd unit.
`timescale 1ns / 1ps
`default_nettype none

`include "rational_arith_unit_assert.svh"

// Rational arithmetic unit. Takes one transaction of opcode plus two
// fractions and returns one transaction of fraction, flag and error code.
// Work is serial: one item at a time, s_tready is high only when the
// sequencer is idle, and a finished result waits in the output register so
// the next item can be taken meanwhile. The steps per item depend on the
// opcode. An item rejected by the operand checks goes straight to the
// output. Mul, div and the comparisons form three products through the
// registered multiplier. Mod adds one 64-step divide after them, and
// is_natural takes one 64-step divide alone. Add and sub run a binary gcd,
// two 64-step divides and then three products; reduce runs the gcd and the
// two divides. Reduce of a zero numerator skips the gcd and the divides.
// Operands use the low DATA_WIDTH bits of each field, sign-extended.
module rational_arith_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config: overflow_limit
  input  wire logic                          cfg_we,
  input  wire logic [rau_pkg::LIMIT_W-1:0]   cfg_wdata,
  // s_tdata: req_type[3:0], a_num[35:4], a_den[67:36], b_num[99:68],
  //          b_den[131:100], zero pad
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [rau_pkg::IN_W-1:0]      s_tdata,
  // m_tdata: res_num[31:0], res_den[63:32], flag[64], error[67:65], zero pad
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [rau_pkg::OUT_W-1:0]          m_tdata
);

  localparam int SH = rau_pkg::FW - DATA_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_GCD_GO, S_GCD_WAIT, S_DIV1_GO, S_DIV1_WAIT,
    S_DIV2_GO, S_DIV2_WAIT, S_MUL0, S_MUL1, S_MUL2, S_MUL3,
    S_DIVR_GO, S_DIVR_WAIT, S_EVAL, S_CHK, S_FINAL
  } state_t;

  function automatic logic signed [rau_pkg::FW-1:0] sx(input logic [rau_pkg::FW-1:0] v);
    logic signed [rau_pkg::FW-1:0] t;
    t = signed'(v << SH);
    return t >>> SH;
  endfunction

  state_t                          state;
  logic [3:0]                      op;
  logic signed [rau_pkg::FW-1:0]   na, da, nb, db;
  logic [rau_pkg::LIMIT_W-1:0]     limit;
  logic [rau_pkg::FW-1:0]          g, q1, q2;
  logic [rau_pkg::PW-1:0]          rem_r;
  logic signed [rau_pkg::PW-1:0]   p0, p1, p2;
  logic signed [rau_pkg::PW-1:0]   rn, rd;
  logic                            flag_r;
  logic                            arith;
  logic [2:0]                      err_r;

  logic signed [rau_pkg::PW-1:0]   rn_next, rd_next;
  logic                            flag_next;
  logic                            arith_next;

  logic [rau_pkg::FW-1:0]          m_na, m_da, m_nb, m_db;
  logic [rau_pkg::FW-1:0]          lim32;
  logic [rau_pkg::PW-1:0]          lim64;
  logic [2:0]                      chk_err;
  logic                            out_free;

  logic                            gcd_start;
  logic [rau_pkg::FW-1:0]          gcd_x, gcd_y, gcd_g;
  rau_pkg::unit_stat_t             gcd_st;
  logic                            div_start;
  logic [rau_pkg::PW-1:0]          div_a, div_b, div_quo, div_rem;
  rau_pkg::unit_stat_t             div_st;
  logic signed [rau_pkg::FW-1:0]   mul_a, mul_b;
  logic signed [rau_pkg::PW-1:0]   mul_p;
  logic signed [rau_pkg::FW-1:0]   ma, mb;

  logic signed [rau_pkg::PW-1:0]   q1x, q2x, rem_s;
  logic                            inv, lt_v, gt_v, eq_v;

  assign m_na  = rau_pkg::mag32(na);
  assign m_da  = rau_pkg::mag32(da);
  assign m_nb  = rau_pkg::mag32(nb);
  assign m_db  = rau_pkg::mag32(db);
  assign lim32 = {1'b0, limit};
  assign lim64 = {{(rau_pkg::PW - rau_pkg::LIMIT_W){1'b0}}, limit};

  // Operand checks, in priority order
  always_comb begin
    chk_err = rau_pkg::ERR_OK;
    priority if (op > rau_pkg::OP_NAT) begin
      chk_err = rau_pkg::ERR_OPC;
    end else if (da == '0) begin
      chk_err = rau_pkg::ERR_ZDEN;
    end else if (m_na > lim32 || m_da > lim32) begin
      chk_err = rau_pkg::ERR_OVF;
    end else if (op <= rau_pkg::OP_EQ && db == '0) begin
      chk_err = rau_pkg::ERR_ZDEN;
    end else if (op <= rau_pkg::OP_EQ && (m_nb > lim32 || m_db > lim32)) begin
      chk_err = rau_pkg::ERR_OVF;
    end else if ((op == rau_pkg::OP_DIV || op == rau_pkg::OP_MOD) && nb == '0) begin
      chk_err = rau_pkg::ERR_DIVZ;
    end else if ((op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB) && (da[31] != db[31])) begin
      // negative common multiple is treated as zero: zero-denominator error
      chk_err = rau_pkg::ERR_ZDEN;
    end else begin
      chk_err = rau_pkg::ERR_OK;
    end
  end

  // gcd operands
  assign gcd_start = (state == S_GCD_GO);
  assign gcd_x = (op == rau_pkg::OP_REDUCE) ? m_na : m_da;
  assign gcd_y = (op == rau_pkg::OP_REDUCE) ? m_da : m_db;

  // divider operands
  assign div_start = (state == S_DIV1_GO) || (state == S_DIV2_GO) || (state == S_DIVR_GO);
  always_comb begin
    if (state == S_DIV1_GO) begin
      div_a = {32'd0, (op == rau_pkg::OP_REDUCE) ? m_na : m_da};
      div_b = {32'd0, g};
    end else if (state == S_DIV2_GO) begin
      div_a = {32'd0, (op == rau_pkg::OP_REDUCE) ? m_da : m_db};
      div_b = {32'd0, g};
    end else if (op == rau_pkg::OP_MOD) begin
      div_a = rau_pkg::mag64(p0);
      div_b = rau_pkg::mag64(p1);
    end else begin
      div_a = {32'd0, m_na};
      div_b = {32'd0, m_da};
    end
  end

  // Scale factors lcm/da and lcm/db
  assign ma = da[31] ? -signed'(q2) : signed'(q2);
  assign mb = db[31] ? -signed'(q1) : signed'(q1);

  // multiplier operands per step and opcode
  always_comb begin
    mul_a = da;
    mul_b = db;
    if (state == S_MUL0) begin
      if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB) begin
        mul_a = na; mul_b = ma;
      end else if (op == rau_pkg::OP_MUL) begin
        mul_a = na; mul_b = nb;
      end else begin
        mul_a = na; mul_b = db;
      end
    end else if (state == S_MUL1) begin
      if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB) begin
        mul_a = nb; mul_b = mb;
      end else if (op == rau_pkg::OP_MUL) begin
        mul_a = da; mul_b = db;
      end else begin
        mul_a = da; mul_b = nb;
      end
    end else if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB) begin
      mul_a = signed'(m_da); mul_b = signed'(q2);
    end
  end

  // Result forming helpers
  assign q1x   = signed'({32'd0, q1});
  assign q2x   = signed'({32'd0, q2});
  assign rem_s = p0[63] ? -signed'(rem_r) : signed'(rem_r);
  assign inv   = da[31] ^ db[31];
  assign lt_v  = inv ? (p0 > p1) : (p0 < p1);
  assign gt_v  = inv ? (p0 < p1) : (p0 > p1);
  assign eq_v  = (p0 == p1);

  // Result values per opcode, taken in the evaluate step
  always_comb begin
    rn_next    = '0;
    rd_next    = 64'sd1;
    flag_next  = 1'b0;
    arith_next = 1'b1;
    unique case (op)
      rau_pkg::OP_ADD: begin
        rn_next = p0 + p1; rd_next = p2;
      end
      rau_pkg::OP_SUB: begin
        rn_next = p0 - p1; rd_next = p2;
      end
      rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
        rn_next = p0; rd_next = p1;
      end
      rau_pkg::OP_MOD: begin
        rn_next = rem_s; rd_next = p2;
      end
      rau_pkg::OP_LT: begin
        flag_next = lt_v; arith_next = 1'b0;
      end
      rau_pkg::OP_GT: begin
        flag_next = gt_v; arith_next = 1'b0;
      end
      rau_pkg::OP_LE: begin
        flag_next = lt_v || eq_v; arith_next = 1'b0;
      end
      rau_pkg::OP_GE: begin
        flag_next = gt_v || eq_v; arith_next = 1'b0;
      end
      rau_pkg::OP_EQ: begin
        flag_next = eq_v; arith_next = 1'b0;
      end
      rau_pkg::OP_REDUCE: begin
        // zero numerator leaves 0/1; else sign lands on the numerator
        if (na != '0) begin
          rn_next = (na[31] ^ da[31]) ? -q1x : q1x;
          rd_next = q2x;
        end
      end
      default: begin
        flag_next  = (rem_r == '0) &&
                     ((da[31] ? na[31] : (na > 0)) || (na == '0));
        arith_next = 1'b0;
      end
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // Sequencer, operand registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      limit    <= rau_pkg::LIMIT_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (m_tvalid && m_tready && !(state == S_FINAL && out_free)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tdata[3:0];
            na    <= sx(s_tdata[35:4]);
            da    <= sx(s_tdata[67:36]);
            nb    <= sx(s_tdata[99:68]);
            db    <= sx(s_tdata[131:100]);
            err_r <= rau_pkg::ERR_OK;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (chk_err != rau_pkg::ERR_OK) begin
            err_r <= chk_err;
            state <= S_FINAL;
          end else if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB) begin
            state <= S_GCD_GO;
          end else if (op == rau_pkg::OP_REDUCE) begin
            state <= (na == '0) ? S_EVAL : S_GCD_GO;
          end else if (op == rau_pkg::OP_NAT) begin
            state <= S_DIVR_GO;
          end else begin
            state <= S_MUL0;
          end
        end
        S_GCD_GO:  state <= S_GCD_WAIT;
        S_GCD_WAIT: begin
          if (gcd_st.done) begin
            g     <= gcd_g;
            state <= S_DIV1_GO;
          end
        end
        S_DIV1_GO: state <= S_DIV1_WAIT;
        S_DIV1_WAIT: begin
          if (div_st.done) begin
            q1    <= div_quo[rau_pkg::FW-1:0];
            state <= S_DIV2_GO;
          end
        end
        S_DIV2_GO: state <= S_DIV2_WAIT;
        S_DIV2_WAIT: begin
          if (div_st.done) begin
            q2    <= div_quo[rau_pkg::FW-1:0];
            state <= (op == rau_pkg::OP_REDUCE) ? S_EVAL : S_MUL0;
          end
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: begin
          p0    <= mul_p;
          state <= S_MUL2;
        end
        S_MUL2: begin
          p1    <= mul_p;
          state <= S_MUL3;
        end
        S_MUL3: begin
          p2    <= mul_p;
          state <= (op == rau_pkg::OP_MOD) ? S_DIVR_GO : S_EVAL;
        end
        S_DIVR_GO: state <= S_DIVR_WAIT;
        S_DIVR_WAIT: begin
          if (div_st.done) begin
            rem_r <= div_rem;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          rn     <= rn_next;
          rd     <= rd_next;
          flag_r <= flag_next;
          arith  <= arith_next;
          state  <= S_CHK;
        end
        S_CHK: begin
          if (arith) begin
            if (rd == '0) begin
              err_r <= rau_pkg::ERR_ZDEN;
            end else if (rau_pkg::mag64(rn) > lim64 || rau_pkg::mag64(rd) > lim64) begin
              err_r <= rau_pkg::ERR_OVF;
            end
          end
          state <= S_FINAL;
        end
        S_FINAL: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (err_r != rau_pkg::ERR_OK) begin
              m_tdata <= {4'd0, err_r, 1'b0, 32'd1, 32'd0};
            end else begin
              m_tdata <= {4'd0, err_r, flag_r, rd[31:0], rn[31:0]};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rau_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .x_in  (gcd_x),
    .y_in  (gcd_y),
    .stat  (gcd_st),
    .g     (gcd_g)
  );

  rau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .stat      (div_st),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  rau_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Checks
  `RAU_ASSERT_IMP(a_div_start_idle, clk, rst, div_start, !div_st.busy, "divider restarted while busy")
  `RAU_ASSERT_IMP(a_gcd_start_idle, clk, rst, gcd_start, !gcd_st.busy, "gcd restarted while busy")
  `RAU_ASSERT_IMP(a_err_frac, clk, rst, m_tvalid && m_tdata[67:65] != rau_pkg::ERR_OK, m_tdata[31:0] == 32'd0 && m_tdata[63:32] == 32'd1 && !m_tdata[64], "error result not 0/1")
  `RAU_ASSERT_NXT(a_final_load, clk, rst, state == S_FINAL && out_free, m_tvalid && state == S_IDLE, "result not loaded")

endmodule

`default_nettype wire

>>> rtl/rau_mul.sv
// Registered signed 32 x 32 multiplier shared by the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rau_mul (
  input  wire logic                           clk,
  input  wire logic signed [rau_pkg::FW-1:0]  a,
  input  wire logic signed [rau_pkg::FW-1:0]  b,
  output logic signed [rau_pkg::PW-1:0]       p
);

  // Full-width product, registered
  always_ff @(posedge clk) begin
    p <= rau_pkg::PW'(a) * rau_pkg::PW'(b);
  end

endmodule

`default_nettype wire

>>> rtl/rau_div.sv
// Bit-serial restoring divider, 64-bit unsigned, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rau_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rau_pkg::PW-1:0]     dividend,
  input  wire logic [rau_pkg::PW-1:0]     divisor,
  output rau_pkg::unit_stat_t             stat,
  output logic [rau_pkg::PW-1:0]          quotient,
  output logic [rau_pkg::PW-1:0]          remainder
);

  localparam int CW = $clog2(rau_pkg::PW);

  logic                   busy;
  logic                   done;
  logic [CW-1:0]          cnt;
  logic [rau_pkg::PW-1:0] quo;
  logic [rau_pkg::PW-1:0] rem;
  logic [rau_pkg::PW-1:0] dsr;
  logic [rau_pkg::PW:0]   trial;
  logic [rau_pkg::PW:0]   diff;
  logic                   fits;

  // Trial subtraction for the next quotient bit
  assign trial = {rem, quo[rau_pkg::PW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  // Iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= fits ? diff[rau_pkg::PW-1:0] : trial[rau_pkg::PW-1:0];
        quo <= {quo[rau_pkg::PW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(rau_pkg::PW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

>>> rtl/rau_gcd.sv
// Binary (shift and subtract) greatest common divisor of two nonzero values.
`timescale 1ns / 1ps
`default_nettype none

module rau_gcd (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rau_pkg::FW-1:0]     x_in,
  input  wire logic [rau_pkg::FW-1:0]     y_in,
  output rau_pkg::unit_stat_t             stat,
  output logic [rau_pkg::FW-1:0]          g
);

  localparam int KW = $clog2(rau_pkg::FW);

  logic                   busy;
  logic                   done;
  logic [rau_pkg::FW-1:0] x;
  logic [rau_pkg::FW-1:0] y;
  logic [KW-1:0]          k;

  // One reduction step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        x    <= x_in;
        y    <= y_in;
        k    <= '0;
      end else if (busy) begin
        priority if (x == y) begin
          g    <= x << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= x - y;
        end else begin
          y <= y - x;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for rational_arith_unit: random and directed fractions.
`timescale 1ns / 1ps

module tb;

  // Opcodes with no operation behind them
  localparam logic [3:0] OP_FIRST_BAD = 4'd12;
  localparam logic [3:0] OP_LAST_BAD  = 4'd15;
  localparam int SETTLE_CYCLES = 300;

  // Holds expected fraction results and predicts them from accepted requests
  class fraction_results;
    typedef struct {
      logic [31:0] num;
      logic [31:0] den;
      logic        flag;
      logic [2:0]  err;
    } frac_res_t;

    frac_res_t pending[$];
    longint unsigned limit;
    int fails;

    function new();
      limit = 64'(rau_pkg::LIMIT_RESET);
      fails = 0;
    endfunction

    function longint unsigned magnitude(longint x);
      return x < 0 ? longint'(0) - x : x;
    endfunction

    function bit over(longint x);
      return magnitude(x) > limit;
    endfunction

    function longint unsigned euclid(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x == 0 ? 1 : x;
    endfunction

    function logic [2:0] operand_err(longint n, longint d);
      if (d == 0) return rau_pkg::ERR_ZDEN;
      if (over(n) || over(d)) return rau_pkg::ERR_OVF;
      return rau_pkg::ERR_OK;
    endfunction

    // Lowest terms with a positive denominator
    function void lowest_terms(input longint n, input longint d,
                               output longint rn, output longint rd);
      longint g;
      if (n == 0) begin
        d = 1;
      end else begin
        g = longint'(euclid(magnitude(n), magnitude(d)));
        n = n / g;
        d = d / g;
      end
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      rn = n;
      rd = d;
    endfunction

    function bit same_value(longint na, longint da, longint nb, longint db);
      longint xn, xd, yn, yd;
      lowest_terms(na, da, xn, xd);
      lowest_terms(nb, db, yn, yd);
      return xn == yn && xd == yd;
    endfunction

    function bit is_less(longint na, longint da, longint nb, longint db);
      longint l, r;
      l = na * db;
      r = da * nb;
      if ((da < 0) != (db < 0)) return l > r;
      return l < r;
    endfunction

    function bit is_greater(longint na, longint da, longint nb, longint db);
      longint l, r;
      l = na * db;
      r = da * nb;
      if ((da < 0) != (db < 0)) return l < r;
      return l > r;
    endfunction

    // Predict the result of one accepted request
    function void note_request(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
      longint na, da, nb, db, rn, rd, p, lcm;
      logic [2:0] err;
      bit flag, arith, pos;
      frac_res_t res;
      na = longint'($signed(an));
      da = longint'($signed(ad));
      nb = longint'($signed(bn));
      db = longint'($signed(bd));
      rn = 0;
      rd = 1;
      flag = 0;
      arith = 1;
      if (op > rau_pkg::OP_NAT) begin
        err = rau_pkg::ERR_OPC;
      end else begin
        err = operand_err(na, da);
        if (err == rau_pkg::ERR_OK && op <= rau_pkg::OP_EQ) err = operand_err(nb, db);
        if (err == rau_pkg::ERR_OK && (op == rau_pkg::OP_DIV || op == rau_pkg::OP_MOD) &&
            nb == 0) err = rau_pkg::ERR_DIVZ;
      end
      if (err == rau_pkg::ERR_OK) begin
        case (op)
          rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
            p = da * db;
            lcm = longint'(magnitude(p) / euclid(magnitude(da), magnitude(db)));
            if (p < 0) begin
              err = rau_pkg::ERR_ZDEN;
            end else if (op == rau_pkg::OP_ADD) begin
              rn = (lcm / da) * na + (lcm / db) * nb;
              rd = lcm;
            end else begin
              rn = na * (lcm / da) - nb * (lcm / db);
              rd = lcm;
            end
          end
          rau_pkg::OP_MUL: begin
            rn = na * nb;
            rd = da * db;
          end
          rau_pkg::OP_DIV: begin
            rn = na * db;
            rd = da * nb;
          end
          rau_pkg::OP_MOD: begin
            rn = (db * na) % (da * nb);
            rd = da * db;
          end
          rau_pkg::OP_LT: begin
            flag = is_less(na, da, nb, db);
            arith = 0;
          end
          rau_pkg::OP_GT: begin
            flag = is_greater(na, da, nb, db);
            arith = 0;
          end
          rau_pkg::OP_LE: begin
            flag = is_less(na, da, nb, db) || same_value(na, da, nb, db);
            arith = 0;
          end
          rau_pkg::OP_GE: begin
            flag = is_greater(na, da, nb, db) || same_value(na, da, nb, db);
            arith = 0;
          end
          rau_pkg::OP_EQ: begin
            flag = same_value(na, da, nb, db);
            arith = 0;
          end
          rau_pkg::OP_REDUCE: lowest_terms(na, da, rn, rd);
          default: begin
            pos = (da < 0) ? (na < 0) : (na > 0);
            flag = ((na % da) == 0) && (pos || na == 0);
            arith = 0;
          end
        endcase
        if (err == rau_pkg::ERR_OK && arith) begin
          if (rd == 0) err = rau_pkg::ERR_ZDEN;
          else if (over(rn) || over(rd)) err = rau_pkg::ERR_OVF;
        end
      end
      if (err != rau_pkg::ERR_OK) begin
        rn = 0;
        rd = 1;
        flag = 0;
      end
      res.num = rn[31:0];
      res.den = rd[31:0];
      res.flag = flag;
      res.err = err;
      pending.insert(pending.size(), res);
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(logic [rau_pkg::OUT_W-1:0] data);
      frac_res_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, data);
        fails++;
        return;
      end
      exp_res = pending.pop_front();
      if (data[31:0] !== exp_res.num) begin
        $display("%0t res_num expected %0d actual %0d", $time,
                 $signed(exp_res.num), $signed(data[31:0]));
        fails++;
      end
      if (data[63:32] !== exp_res.den) begin
        $display("%0t res_den expected %0d actual %0d", $time,
                 $signed(exp_res.den), $signed(data[63:32]));
        fails++;
      end
      if (data[64] !== exp_res.flag) begin
        $display("%0t flag expected %0d actual %0d", $time, exp_res.flag, data[64]);
        fails++;
      end
      if (data[67:65] !== exp_res.err) begin
        $display("%0t error expected %0d actual %0d", $time, exp_res.err, data[67:65]);
        fails++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [rau_pkg::LIMIT_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [rau_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [rau_pkg::OUT_W-1:0] m_tdata;

  fraction_results board = new();
  int burst_left = 0;
  int hold_cycles = 0;
  int unsigned cyc = 0;

  rational_arith_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Watch both sides for completed transactions
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      board.note_request(s_tdata[3:0], s_tdata[35:4], s_tdata[67:36],
                         s_tdata[99:68], s_tdata[131:100]);
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // Receiver: changing stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else begin
      case ((cyc >> 9) % 4)
        0: m_tready <= 1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (cyc % 7) != 0;
      endcase
    end
  end

  // Send one request; valid stays high after acceptance unless a gap follows
  task automatic send_req(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1;
    s_tdata <= {4'b0, bd, bn, ad, an, op};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drain all results, let the block settle, then write the limit
  task automatic set_limit(logic [rau_pkg::LIMIT_W-1:0] value);
    s_tvalid <= 0;
    burst_left = 0;
    do @(posedge clk); while (board.pending.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    board.limit = 64'(value);
  endtask

  function automatic logic [31:0] rand_part(longint unsigned lim);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom_range(0, 50);
      6, 7: v = $urandom_range(0, lim > 32'h7fffffff ? 32'h7fffffff : 32'(lim));
      8: v = $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = 32'(lim);
          2: v = 32'(lim + 1);
          3: v = 32'h80000000;
          default: v = 32'h7fffffff;
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic [31:0] rand_den(longint unsigned lim);
    logic [31:0] v;
    v = rand_part(lim);
    if (v == 0 && $urandom_range(0, 3) != 0) v = 1;
    return v;
  endfunction

  task automatic random_phase(int count, longint unsigned lim);
    logic [3:0] op;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) op = 4'($urandom_range(OP_FIRST_BAD, OP_LAST_BAD));
      else op = 4'($urandom_range(rau_pkg::OP_ADD, rau_pkg::OP_NAT));
      // Long receiver hold-off while requests keep coming
      if (i == count / 3) hold_cycles = 2000;
      send_req(op, rand_part(lim), rand_den(lim), rand_part(lim), rand_den(lim));
    end
  endtask

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed cases under the reset limit
    send_req(rau_pkg::OP_ADD, 1, 2, 1, 3);
    send_req(rau_pkg::OP_ADD, 1, 2, 1, -3);     // denominators of opposite sign
    send_req(rau_pkg::OP_SUB, -5, 6, 7, 4);
    send_req(rau_pkg::OP_MUL, -3, 4, 5, -7);
    send_req(rau_pkg::OP_MUL, 5000, 1, 5000, 1); // result past the limit
    send_req(rau_pkg::OP_DIV, 2, 3, -4, 5);
    send_req(rau_pkg::OP_DIV, 2, 3, 0, 5);      // divide by zero
    send_req(rau_pkg::OP_MOD, 7, 2, 1, 3);
    send_req(rau_pkg::OP_MOD, -7, 2, 1, -3);
    send_req(rau_pkg::OP_MOD, 1, 1, 0, 1);
    send_req(rau_pkg::OP_LT, 1, 2, 2, 3);
    send_req(rau_pkg::OP_GT, 1, -2, 2, 3);
    send_req(rau_pkg::OP_LE, 2, 4, 1, 2);
    send_req(rau_pkg::OP_GE, -1, 3, 1, -3);
    send_req(rau_pkg::OP_EQ, 2, 4, -1, -2);
    send_req(rau_pkg::OP_REDUCE, 6, -4, 0, 0);
    send_req(rau_pkg::OP_REDUCE, 0, -5, 0, 0);
    send_req(rau_pkg::OP_NAT, 6, 3, 0, 0);
    send_req(rau_pkg::OP_NAT, -6, -3, 0, 0);
    send_req(rau_pkg::OP_NAT, 5, 2, 0, 0);
    send_req(OP_FIRST_BAD, 1, 1, 1, 1);
    send_req(OP_LAST_BAD, 1, 1, 1, 1);
    send_req(rau_pkg::OP_ADD, 1, 0, 1, 1);      // zero denominator in a
    send_req(rau_pkg::OP_SUB, 1, 1, 1, 0);      // zero denominator in b
    send_req(rau_pkg::OP_EQ, 10000001, 1, 1, 1); // operand past the limit

    random_phase(150, 64'(rau_pkg::LIMIT_RESET));
    set_limit(1);
    random_phase(120, 1);
    set_limit(31'h7fffffff);
    random_phase(180, 31'h7fffffff);
    set_limit(1000);
    random_phase(150, 1000);

    s_tvalid <= 0;
    do @(posedge clk); while (board.pending.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
